// ----- sv/srale_pkg.sv -----
// Shared constants, codes and types of the sparse row averaging block.
package srale_pkg;

    // Field widths
    localparam int TYPE_W   = 3;
    localparam int SLOT_W   = 13;
    localparam int WORD_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int VC_W     = 11;
    localparam int RS_W     = 14;
    localparam int CI_W     = 10;

    // Defaults for the top level parameters
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 8192;
    localparam int DEF_LEVELS       = 8;

    // Vertex count after reset
    localparam int VC_RESET = 1024;

    // Quotient bits produced by the serial divide
    localparam int DIV_STEPS = 32;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_LOAD_ROW  = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_LOAD_COL  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_WRITE_VAL = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_COMPUTE   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_READ_VAL  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd2;

    // Write enables toward the stores
    typedef struct packed {
        logic rs_we;
        logic ci_we;
        logic val_we;
    } store_we_t;

endpackage

// ----- sv/srale_alu.sv -----
// Shared add/subtract unit with carry out used by the level search, accumulate, divide and sign steps.
module srale_alu #(
    parameter int W = 46
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic         sub,
    output logic [W-1:0] y,
    output logic         cout
);

    logic [W-1:0] b_in;
    logic [W:0]   total;

    // Invert and carry in for subtract; carry out means a >= b unsigned
    always_comb
    begin
        b_in  = sub ? ~b : b;
        total = {1'b0, a} + {1'b0, b_in} + {{W{1'b0}}, sub};
        y     = total[W-1:0];
        cout  = total[W];
    end

endmodule

// ----- sv/srale_store.sv -----
// Row start, column index and level value memories, one write and one read port each.
module srale_store #(
    parameter int MAX_VERTICES = srale_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = srale_pkg::DEF_MAX_EDGES,
    parameter int LEVELS       = srale_pkg::DEF_LEVELS,
    localparam int RS_DEPTH    = MAX_VERTICES + 1,
    localparam int VAL_DEPTH   = LEVELS * MAX_VERTICES,
    localparam int RS_AW       = $clog2(RS_DEPTH),
    localparam int CI_AW       = $clog2(MAX_EDGES),
    localparam int VAL_AW      = $clog2(VAL_DEPTH)
) (
    input  logic                           clk,
    input  srale_pkg::store_we_t           we,
    input  logic [RS_AW-1:0]               rs_waddr,
    input  logic [srale_pkg::RS_W-1:0]     rs_wdata,
    input  logic [RS_AW-1:0]               rs_raddr,
    output logic [srale_pkg::RS_W-1:0]     rs_rdata,
    input  logic [CI_AW-1:0]               ci_waddr,
    input  logic [srale_pkg::CI_W-1:0]     ci_wdata,
    input  logic [CI_AW-1:0]               ci_raddr,
    output logic [srale_pkg::CI_W-1:0]     ci_rdata,
    input  logic [VAL_AW-1:0]              val_waddr,
    input  logic [srale_pkg::VALUE_W-1:0]  val_wdata,
    input  logic [VAL_AW-1:0]              val_raddr,
    output logic [srale_pkg::VALUE_W-1:0]  val_rdata
);

    logic [srale_pkg::RS_W-1:0]    rs_mem  [RS_DEPTH];
    logic [srale_pkg::CI_W-1:0]    ci_mem  [MAX_EDGES];
    logic [srale_pkg::VALUE_W-1:0] val_mem [VAL_DEPTH];

    // Row starts
    always_ff @(posedge clk)
    begin
        if (we.rs_we)
        begin
            rs_mem[rs_waddr] <= rs_wdata;
        end
        rs_rdata <= rs_mem[rs_raddr];
    end

    // Column indices
    always_ff @(posedge clk)
    begin
        if (we.ci_we)
        begin
            ci_mem[ci_waddr] <= ci_wdata;
        end
        ci_rdata <= ci_mem[ci_raddr];
    end

    // Level values
    always_ff @(posedge clk)
    begin
        if (we.val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata <= val_mem[val_raddr];
    end

endmodule

// ----- sv/sparse_row_average_level_step.sv -----
// Top level: request sequencer around the shared adder and the graph and value stores.
//
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------
//  request  | start / busy         | req_type, slot, word
//  result   | done (one cycle)     | value, status
//  config   | cfg_valid/cfg_ready  | cfg_data (vertex count)
//
// Loads, value writes, unknown codes and slots outside a store return their
// result from decode; value reads add one store read. A compute runs the
// level search (the level search subtracts the vertex count once per cycle),
// the row start reads, one column read and one value read per edge, and the
// serial divide on the shared adder.
// Reset clears the sequencer and the result strobe and sets the vertex count to
// 1024; the stores hold nothing defined until written. busy stays high from accept
// until the result cycle. The receiver cannot stall the result.
module sparse_row_average_level_step #(
    parameter int MAX_VERTICES = srale_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = srale_pkg::DEF_MAX_EDGES,
    parameter int LEVELS       = srale_pkg::DEF_LEVELS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [srale_pkg::TYPE_W-1:0]         req_type,
    input  logic [srale_pkg::SLOT_W-1:0]         slot,
    input  logic signed [srale_pkg::WORD_W-1:0]  word,
    output logic                                 done,
    output logic signed [srale_pkg::VALUE_W-1:0] value,
    output logic [srale_pkg::STATUS_W-1:0]       status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [srale_pkg::VC_W-1:0]           cfg_data
);

    localparam int RS_AW  = $clog2(MAX_VERTICES + 1);
    localparam int CI_AW  = $clog2(MAX_EDGES);
    localparam int VAL_AW = $clog2(LEVELS * MAX_VERTICES);
    localparam int N_W    = $clog2(MAX_VERTICES + 1);
    localparam int E_W    = $clog2(MAX_EDGES + 1);
    localparam int SUM_W  = srale_pkg::VALUE_W + $clog2(MAX_EDGES) + 1;
    localparam int CNT_W  = $clog2(srale_pkg::DIV_STEPS);
    localparam int QW     = srale_pkg::DIV_STEPS;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_READV   = 4'd2;
    localparam logic [3:0] S_LEVEL   = 4'd3;
    localparam logic [3:0] S_RSA     = 4'd4;
    localparam logic [3:0] S_RSB     = 4'd5;
    localparam logic [3:0] S_RSC     = 4'd6;
    localparam logic [3:0] S_COLRD   = 4'd7;
    localparam logic [3:0] S_COLCHK  = 4'd8;
    localparam logic [3:0] S_VALACC  = 4'd9;
    localparam logic [3:0] S_DIVPREP = 4'd10;
    localparam logic [3:0] S_DIV     = 4'd11;
    localparam logic [3:0] S_DIVFIN  = 4'd12;

    // Control registers
    logic [3:0]                         state_reg, state_next;
    logic                               done_reg, done_next;
    logic [srale_pkg::VC_W-1:0]         vc_reg, vc_next;

    // Data registers
    logic [srale_pkg::TYPE_W-1:0]       type_reg, type_next;
    logic [srale_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic [srale_pkg::WORD_W-1:0]       word_reg, word_next;
    logic [srale_pkg::SLOT_W-1:0]       vrem_reg, vrem_next;
    logic                               first_reg, first_next;
    logic [E_W-1:0]                     beg_reg, beg_next;
    logic [E_W-1:0]                     end_reg, end_next;
    logic [E_W-1:0]                     deg_reg, deg_next;
    logic [E_W-1:0]                     j_reg, j_next;
    logic [VAL_AW-1:0]                  base_reg, base_next;
    logic [SUM_W-1:0]                   sum_reg, sum_next;
    logic                               neg_reg, neg_next;
    logic [E_W-1:0]                     drem_reg, drem_next;
    logic [QW-1:0]                      q_reg, q_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic [srale_pkg::VALUE_W-1:0]      value_reg, value_next;
    logic [srale_pkg::STATUS_W-1:0]     status_reg, status_next;

    // Shared adder
    logic [SUM_W-1:0]                   alu_a, alu_b, alu_y;
    logic                               alu_sub, alu_cout;

    // Store ports
    srale_pkg::store_we_t               st_we;
    logic [RS_AW-1:0]                   rs_raddr;
    logic [srale_pkg::RS_W-1:0]         rs_rdata;
    logic [CI_AW-1:0]                   ci_raddr;
    logic [srale_pkg::CI_W-1:0]         ci_rdata;
    logic [VAL_AW-1:0]                  val_raddr;
    logic [srale_pkg::VALUE_W-1:0]      val_wdata;
    logic [srale_pkg::VALUE_W-1:0]      val_rdata;

    // Derived values
    logic [N_W-1:0]                     n_eff;
    logic [31:0]                        limit;
    logic                               slot_ok;
    logic [E_W-1:0]                     rs_clamped;
    logic [E_W:0]                       trial;

    // Clamp a row start to the edge count
    function automatic logic [E_W-1:0] clamp_edge(input logic [srale_pkg::RS_W-1:0] p);
        logic [E_W-1:0] r;
        if (32'(p) > 32'(MAX_EDGES))
        begin
            r = E_W'(MAX_EDGES);
        end
        else
        begin
            r = E_W'(p);
        end
        return r;
    endfunction

    // Effective vertex count and value slot limit
    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (32'(vc_reg) > 32'(MAX_VERTICES))
        begin
            n_eff = N_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = N_W'(vc_reg);
        end
        limit   = 32'(LEVELS) * 32'(n_eff);
        slot_ok = 32'(slot_reg) < limit;
    end

    assign rs_clamped = clamp_edge(rs_rdata);
    assign trial      = {drem_reg, q_reg[QW-1]};

    srale_alu #(
        .W (SUM_W)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .sub  (alu_sub),
        .y    (alu_y),
        .cout (alu_cout)
    );

    srale_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .LEVELS       (LEVELS)
    ) u_store (
        .clk       (clk),
        .we        (st_we),
        .rs_waddr  (RS_AW'(slot_reg)),
        .rs_wdata  (word_reg[srale_pkg::RS_W-1:0]),
        .rs_raddr  (rs_raddr),
        .rs_rdata  (rs_rdata),
        .ci_waddr  (CI_AW'(slot_reg)),
        .ci_wdata  (word_reg[srale_pkg::CI_W-1:0]),
        .ci_raddr  (ci_raddr),
        .ci_rdata  (ci_rdata),
        .val_waddr (VAL_AW'(slot_reg)),
        .val_wdata (val_wdata),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata)
    );

    // Read addresses
    always_comb
    begin
        rs_raddr = (state_reg == S_RSA) ? RS_AW'(vrem_reg) : RS_AW'(32'(vrem_reg) + 32'd1);
        ci_raddr = j_reg[CI_AW-1:0];
        if (state_reg == S_DECODE)
        begin
            val_raddr = VAL_AW'(slot_reg);
        end
        else
        begin
            val_raddr = VAL_AW'(32'(base_reg) + 32'(ci_rdata));
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        vc_next     = vc_reg;
        type_next   = type_reg;
        slot_next   = slot_reg;
        word_next   = word_reg;
        vrem_next   = vrem_reg;
        first_next  = first_reg;
        beg_next    = beg_reg;
        end_next    = end_reg;
        deg_next    = deg_reg;
        j_next      = j_reg;
        base_next   = base_reg;
        sum_next    = sum_reg;
        neg_next    = neg_reg;
        drem_next   = drem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        value_next  = value_reg;
        status_next = status_reg;
        st_we       = '0;
        val_wdata   = word_reg;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b1;

        // Take the vertex count
        if (cfg_valid && cfg_ready)
        begin
            vc_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    type_next  = req_type;
                    slot_next  = slot;
                    word_next  = word;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                value_next  = '0;
                status_next = srale_pkg::ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
                case (type_reg)
                    srale_pkg::REQ_LOAD_ROW:
                    begin
                        if (32'(slot_reg) <= 32'(MAX_VERTICES))
                        begin
                            st_we.rs_we = 1'b1;
                        end
                        else
                        begin
                            status_next = srale_pkg::ST_INDEX;
                        end
                    end
                    srale_pkg::REQ_LOAD_COL:
                    begin
                        if (32'(slot_reg) < 32'(MAX_EDGES))
                        begin
                            st_we.ci_we = 1'b1;
                        end
                        else
                        begin
                            status_next = srale_pkg::ST_INDEX;
                        end
                    end
                    srale_pkg::REQ_WRITE_VAL:
                    begin
                        if (slot_ok)
                        begin
                            st_we.val_we = 1'b1;
                        end
                        else
                        begin
                            status_next = srale_pkg::ST_INDEX;
                        end
                    end
                    srale_pkg::REQ_READ_VAL:
                    begin
                        if (slot_ok)
                        begin
                            done_next  = 1'b0;
                            state_next = S_READV;
                        end
                        else
                        begin
                            status_next = srale_pkg::ST_INDEX;
                        end
                    end
                    srale_pkg::REQ_COMPUTE:
                    begin
                        if (slot_ok)
                        begin
                            vrem_next  = slot_reg;
                            first_next = 1'b1;
                            done_next  = 1'b0;
                            state_next = S_LEVEL;
                        end
                        else
                        begin
                            status_next = srale_pkg::ST_INDEX;
                        end
                    end
                    default:
                    begin
                        status_next = srale_pkg::ST_INDEX;
                    end
                endcase
            end

            S_READV:
            begin
                value_next = val_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // Subtract the vertex count until the vertex remains
            S_LEVEL:
            begin
                alu_a = SUM_W'(vrem_reg);
                alu_b = SUM_W'(n_eff);
                if (alu_cout)
                begin
                    vrem_next  = alu_y[srale_pkg::SLOT_W-1:0];
                    first_next = 1'b0;
                end
                else if (first_reg)
                begin
                    value_next  = '0;
                    status_next = srale_pkg::ST_INDEX;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_RSA;
                end
            end

            S_RSA:
            begin
                base_next  = VAL_AW'(32'(slot_reg) - 32'(vrem_reg) - 32'(n_eff));
                state_next = S_RSB;
            end

            S_RSB:
            begin
                beg_next   = rs_clamped;
                state_next = S_RSC;
            end

            // Check for an empty row
            S_RSC:
            begin
                end_next = rs_clamped;
                deg_next = rs_clamped - beg_reg;
                j_next   = beg_reg;
                sum_next = '0;
                if (rs_clamped <= beg_reg)
                begin
                    st_we.val_we = 1'b1;
                    val_wdata    = '0;
                    value_next   = '0;
                    status_next  = srale_pkg::ST_ZERO;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_COLRD;
                end
            end

            S_COLRD:
            begin
                state_next = S_COLCHK;
            end

            // Drop the request on a column at or beyond the vertex count
            S_COLCHK:
            begin
                if (32'(ci_rdata) >= 32'(n_eff))
                begin
                    value_next  = '0;
                    status_next = srale_pkg::ST_INDEX;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_VALACC;
                end
            end

            // Accumulate the neighbour value and advance the edge
            S_VALACC:
            begin
                alu_sub  = 1'b0;
                alu_a    = sum_reg;
                alu_b    = {{(SUM_W - srale_pkg::VALUE_W){val_rdata[srale_pkg::VALUE_W-1]}},
                            val_rdata};
                sum_next = alu_y;
                j_next   = j_reg + E_W'(1);
                if (j_reg + E_W'(1) == end_reg)
                begin
                    state_next = S_DIVPREP;
                end
                else
                begin
                    state_next = S_COLRD;
                end
            end

            // Take the magnitude and preload the high remainder
            S_DIVPREP:
            begin
                alu_a    = '0;
                alu_b    = sum_reg;
                neg_next = sum_reg[SUM_W-1];
                if (sum_reg[SUM_W-1])
                begin
                    drem_next = E_W'(alu_y >> QW);
                    q_next    = alu_y[QW-1:0];
                end
                else
                begin
                    drem_next = E_W'(sum_reg >> QW);
                    q_next    = sum_reg[QW-1:0];
                end
                cnt_next   = '0;
                state_next = S_DIV;
            end

            // One restoring divide step per cycle
            S_DIV:
            begin
                alu_a = SUM_W'(trial);
                alu_b = SUM_W'(deg_reg);
                if (alu_cout)
                begin
                    drem_next = alu_y[E_W-1:0];
                end
                else
                begin
                    drem_next = trial[E_W-1:0];
                end
                q_next   = {q_reg[QW-2:0], alu_cout};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(srale_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DIVFIN;
                end
            end

            // Restore the sign, store and return the average
            S_DIVFIN:
            begin
                alu_a = '0;
                alu_b = SUM_W'(q_reg);
                if (neg_reg)
                begin
                    val_wdata = alu_y[srale_pkg::VALUE_W-1:0];
                end
                else
                begin
                    val_wdata = q_reg;
                end
                st_we.val_we = 1'b1;
                value_next   = val_wdata;
                status_next  = srale_pkg::ST_OK;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            vc_reg    <= srale_pkg::VC_W'(srale_pkg::VC_RESET);
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            vc_reg    <= vc_next;
        end
    end

    // Datapath state
    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        slot_reg   <= slot_next;
        word_reg   <= word_next;
        vrem_reg   <= vrem_next;
        first_reg  <= first_next;
        beg_reg    <= beg_next;
        end_reg    <= end_next;
        deg_reg    <= deg_next;
        j_reg      <= j_next;
        base_reg   <= base_next;
        sum_reg    <= sum_next;
        neg_reg    <= neg_next;
        drem_reg   <= drem_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // An accepted request always enters decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DECODE))
        else $error("accepted request did not enter decode");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result strobe without a request in flight");

    // The divide remainder stays below the degree
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (drem_reg < deg_reg))
        else $error("divide remainder not below degree");

    // The edge walk stays inside the row
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COLRD) |-> (j_reg < end_reg && j_reg >= beg_reg))
        else $error("edge pointer outside the row");

    // Result status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (status_reg == srale_pkg::ST_OK || status_reg == srale_pkg::ST_ZERO ||
                      status_reg == srale_pkg::ST_INDEX))
        else $error("undefined status code");

endmodule

// ----- bench/tb.sv -----
// Testbench for the sparse row averaging block: directed and random requests against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srale_pkg::*;

    localparam int MAX_VERTICES    = DEF_MAX_VERTICES;
    localparam int MAX_EDGES       = DEF_MAX_EDGES;
    localparam int LEVELS          = DEF_LEVELS;
    localparam int RANDOM_REQUESTS = 950;
    localparam int DRAIN_CYCLES    = 60;

    // Request codes the block does not implement
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_HI = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } level_result_t;

    typedef struct {
        bit          defined;
        bit          bad_column;
        int unsigned degree;
        longint      sum;
    } row_walk_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [TYPE_W-1:0]         req_type = '0;
    logic [SLOT_W-1:0]         slot = '0;
    logic signed [WORD_W-1:0]  word = '0;
    logic                      done;
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [VC_W-1:0]           cfg_data = '0;

    // Predicted contents of the graph and value stores
    logic [RS_W-1:0]    row_start_mem [0:MAX_VERTICES];
    bit                 row_start_set [0:MAX_VERTICES];
    logic [CI_W-1:0]    column_mem    [0:MAX_EDGES-1];
    bit                 column_set    [0:MAX_EDGES-1];
    logic [VALUE_W-1:0] value_mem     [0:LEVELS*MAX_VERTICES-1];
    bit                 value_set     [0:LEVELS*MAX_VERTICES-1];
    logic [VC_W-1:0]    vertex_count_reg = VC_RESET;

    level_result_t pending_results[$];
    int unsigned   requests_sent = 0;
    int unsigned   idle_pct = 28;
    int            mismatch_count = 0;

    sparse_row_average_level_step #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES   (MAX_EDGES),
        .LEVELS      (LEVELS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req_type (req_type),
        .slot     (slot),
        .word     (word),
        .done     (done),
        .value    (value),
        .status   (status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial forever #4 clk = ~clk;

    // Bound the run
    initial
    begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic int unsigned vertices_in_use();
        if (vertex_count_reg == 0)
            return 1;
        if (vertex_count_reg > MAX_VERTICES)
            return MAX_VERTICES;
        return vertex_count_reg;
    endfunction

    function automatic int unsigned clamp_edge(logic [RS_W-1:0] p);
        return (p > MAX_EDGES) ? MAX_EDGES : p;
    endfunction

    // Walk one row, summing neighbour values; stop at the first bad column
    function automatic row_walk_t walk_row(int unsigned v, int unsigned base, int unsigned n);
        row_walk_t   r;
        int unsigned lo_edge;
        int unsigned hi_edge;
        int unsigned c;
        r.defined    = row_start_set[v] && row_start_set[v + 1];
        r.bad_column = 1'b0;
        r.degree     = 0;
        r.sum        = 0;
        if (!r.defined)
            return r;
        lo_edge  = clamp_edge(row_start_mem[v]);
        hi_edge  = clamp_edge(row_start_mem[v + 1]);
        r.degree = (hi_edge > lo_edge) ? hi_edge - lo_edge : 0;
        for (int unsigned j = lo_edge; j < hi_edge; j++)
        begin
            if (!column_set[j])
            begin
                r.defined = 1'b0;
                return r;
            end
            c = column_mem[j];
            if (c >= n)
            begin
                r.bad_column = 1'b1;
                return r;
            end
            if (!value_set[base + c])
            begin
                r.defined = 1'b0;
                return r;
            end
            r.sum += longint'($signed(value_mem[base + c]));
        end
        return r;
    endfunction

    // True when a request touches only store entries that hold written data
    function automatic bit reads_defined(logic [TYPE_W-1:0] kind, logic [SLOT_W-1:0] s);
        int unsigned n;
        int unsigned lvl;
        row_walk_t   r;
        n = vertices_in_use();
        if (s >= LEVELS * n)
            return 1'b1;
        if (kind == REQ_READ_VAL)
            return value_set[s];
        if (kind != REQ_COMPUTE)
            return 1'b1;
        lvl = s / n;
        if (lvl == 0)
            return 1'b1;
        r = walk_row(s % n, (lvl - 1) * n, n);
        return r.defined;
    endfunction

    // Apply one request to the predicted stores and return its result word
    function automatic level_result_t step_level_store(logic [TYPE_W-1:0] kind,
                                                       logic [SLOT_W-1:0] s,
                                                       logic [WORD_W-1:0] data);
        level_result_t res;
        int unsigned   n;
        int unsigned   lvl;
        row_walk_t     r;
        longint        quotient;
        res.value  = '0;
        res.status = ST_OK;
        n = vertices_in_use();
        case (kind)
            REQ_LOAD_ROW:
                if (s <= MAX_VERTICES)
                begin
                    row_start_mem[s] = data[RS_W-1:0];
                    row_start_set[s] = 1'b1;
                end
                else
                    res.status = ST_INDEX;
            REQ_LOAD_COL:
                if (s < MAX_EDGES)
                begin
                    column_mem[s] = data[CI_W-1:0];
                    column_set[s] = 1'b1;
                end
                else
                    res.status = ST_INDEX;
            REQ_WRITE_VAL:
                if (s < LEVELS * n)
                begin
                    value_mem[s] = data;
                    value_set[s] = 1'b1;
                end
                else
                    res.status = ST_INDEX;
            REQ_READ_VAL:
                if (s < LEVELS * n)
                    res.value = value_mem[s];
                else
                    res.status = ST_INDEX;
            REQ_COMPUTE:
            begin
                lvl = s / n;
                if (s >= LEVELS * n || lvl == 0)
                    res.status = ST_INDEX;
                else
                begin
                    r = walk_row(s % n, (lvl - 1) * n, n);
                    if (r.degree == 0)
                    begin
                        value_mem[s] = '0;
                        value_set[s] = 1'b1;
                        res.status   = ST_ZERO;
                    end
                    else if (r.bad_column)
                        res.status = ST_INDEX;
                    else
                    begin
                        quotient     = r.sum / longint'(r.degree);
                        res.value    = quotient[VALUE_W-1:0];
                        value_mem[s] = res.value;
                        value_set[s] = 1'b1;
                    end
                end
            end
            default:
                res.status = ST_INDEX;
        endcase
        return res;
    endfunction

    // Send one request word; skip it if it would read unwritten store entries
    task automatic issue_request(logic [TYPE_W-1:0] kind, logic [SLOT_W-1:0] s,
                                 logic [WORD_W-1:0] data);
        level_result_t res;
        if (!reads_defined(kind, s))
            return;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= kind;
        slot     <= s;
        word     <= data;
        do
            @(posedge clk);
        while (busy);
        res = step_level_store(kind, s, data);
        pending_results.push_back(res);
        requests_sent++;
    endtask

    // Hold off new requests until every result is back
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_vertex_count(logic [VC_W-1:0] count);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        vertex_count_reg = count;
    endtask

    function automatic logic [VC_W-1:0] random_vertex_count();
        case ($urandom_range(0, 5))
            0:       return VC_W'(MAX_VERTICES);
            1:       return 11'd1;
            2:       return VC_W'($urandom_range(2, 16));
            3:       return VC_W'($urandom_range(17, MAX_VERTICES - 1));
            4:       return '1;
            default: return VC_W'($urandom_range(MAX_VERTICES + 1, 2046));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_level_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            4:       return $urandom_range(0, 131071);
            default: return $urandom;
        endcase
    endfunction

    // Lay out a small window of rows, seed level zero, then average upward
    task automatic build_and_average_window();
        int unsigned n;
        int unsigned span;
        int unsigned base_v;
        int unsigned edge_at;
        int unsigned degree;
        int unsigned col;
        int unsigned top_level;
        int unsigned target;
        n       = vertices_in_use();
        span    = $urandom_range(1, (n < 6) ? n : 6);
        base_v  = $urandom_range(0, n - span);
        edge_at = $urandom_range(0, MAX_EDGES - 64);
        for (int i = 0; i < span; i++)
        begin
            issue_request(REQ_LOAD_ROW, SLOT_W'(base_v + i),
                          (32'($urandom) & 32'hFFFF_C000) | 32'(edge_at));
            degree = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 6);
            for (int e = 0; e < degree; e++)
            begin
                // mostly columns inside the window, now and then a stray or bad one
                case ($urandom_range(0, 19))
                    0:       col = (n < MAX_VERTICES) ? $urandom_range(n, MAX_VERTICES - 1)
                                                      : $urandom_range(0, n - 1);
                    1:       col = $urandom_range(0, n - 1);
                    default: col = base_v + $urandom_range(0, span - 1);
                endcase
                issue_request(REQ_LOAD_COL, SLOT_W'(edge_at),
                              (32'($urandom) & 32'hFFFF_FC00) | 32'(col));
                edge_at++;
            end
        end
        issue_request(REQ_LOAD_ROW, SLOT_W'(base_v + span),
                      (32'($urandom) & 32'hFFFF_C000) | 32'(edge_at));
        for (int i = 0; i < span; i++)
            issue_request(REQ_WRITE_VAL, SLOT_W'(base_v + i), random_level_value());
        top_level = ($urandom_range(0, 3) == 0) ? $urandom_range(1, LEVELS - 1)
                                                : $urandom_range(1, 2);
        for (int unsigned l = 1; l <= top_level; l++)
        begin
            for (int i = 0; i < span; i++)
            begin
                target = l * n + base_v + i;
                issue_request(REQ_COMPUTE, SLOT_W'(target), $urandom);
                if ($urandom_range(0, 4) == 0)
                    issue_request(REQ_READ_VAL, SLOT_W'(target), $urandom);
            end
        end
    endtask

    // Fire a few unstructured requests, slots biased toward the range edges
    task automatic send_stray_requests();
        int unsigned       n;
        int unsigned       limit;
        logic [SLOT_W-1:0] s;
        n     = vertices_in_use();
        limit = LEVELS * n;
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 3))
                0:       s = $urandom_range(limit - 2, (limit + 1 > 8191) ? 8191 : limit + 1);
                1:       s = $urandom_range(0, n + 1);
                default: s = $urandom;
            endcase
            issue_request(TYPE_W'($urandom_range(0, 7)), s, $urandom);
        end
    endtask

    task automatic test_loads_and_bounds();
        // row starts at both ends of the table and one past it
        issue_request(REQ_LOAD_ROW, SLOT_W'(0), 32'h0000_0000);
        issue_request(REQ_LOAD_ROW, SLOT_W'(MAX_VERTICES), 32'hFFFF_C000);
        issue_request(REQ_LOAD_ROW, SLOT_W'(MAX_VERTICES + 1), 32'h0000_0001);
        // last edge slot; upper bits of the word are dropped
        issue_request(REQ_LOAD_COL, SLOT_W'(MAX_EDGES - 1), 32'hFFFF_FC00);
        // most negative value in the last value slot, read back
        issue_request(REQ_WRITE_VAL, SLOT_W'(MAX_EDGES - 1), 32'h8000_0000);
        issue_request(REQ_READ_VAL, SLOT_W'(MAX_EDGES - 1), 32'hFFFF_FFFF);
        for (int k = REQ_UNKNOWN_LO; k <= REQ_UNKNOWN_HI; k++)
            issue_request(TYPE_W'(k), '1, 32'hFFFF_FFFF);
        // level zero has nothing below it
        issue_request(REQ_COMPUTE, SLOT_W'(MAX_VERTICES - 1), 32'h0000_0000);
    endtask

    task automatic test_compute_cases();
        // vertex 0 owns edge slots 0 and 1, vertex 1 none
        issue_request(REQ_LOAD_ROW, SLOT_W'(1), 32'd2);
        issue_request(REQ_LOAD_ROW, SLOT_W'(2), 32'd2);
        issue_request(REQ_LOAD_COL, SLOT_W'(0), 32'd0);
        issue_request(REQ_LOAD_COL, SLOT_W'(1), 32'd1);
        // sum wider than 32 bits
        issue_request(REQ_WRITE_VAL, SLOT_W'(0), 32'h7FFF_FFFF);
        issue_request(REQ_WRITE_VAL, SLOT_W'(1), 32'h7FFF_FFFF);
        issue_request(REQ_COMPUTE, SLOT_W'(MAX_VERTICES), 32'd0);
        issue_request(REQ_COMPUTE, SLOT_W'(MAX_VERTICES + 1), 32'd0);
        // negative odd sum truncates toward zero
        issue_request(REQ_WRITE_VAL, SLOT_W'(0), 32'h0000_0000);
        issue_request(REQ_WRITE_VAL, SLOT_W'(1), 32'hFFFF_FFFD);
        // row ends past the edge table clamp to its size
        issue_request(REQ_LOAD_ROW, SLOT_W'(3), 32'd8190);
        issue_request(REQ_LOAD_ROW, SLOT_W'(4), 32'h0000_3FFF);
        issue_request(REQ_LOAD_COL, SLOT_W'(MAX_EDGES - 2), 32'd1);
        issue_request(REQ_COMPUTE, SLOT_W'(MAX_VERTICES + 3), 32'd0);
        // both ends clamp to the same edge: empty row
        issue_request(REQ_LOAD_ROW, SLOT_W'(5), 32'd9000);
        issue_request(REQ_COMPUTE, SLOT_W'(MAX_VERTICES + 4), 32'd0);
    endtask

    task automatic test_vertex_count_limits();
        // zero acts as a single vertex: column 1 is out of range
        write_vertex_count('0);
        issue_request(REQ_COMPUTE, SLOT_W'(1), 32'd0);
        issue_request(REQ_WRITE_VAL, SLOT_W'(LEVELS), 32'h1234_5678);
        // all ones clamps to the full vertex table
        write_vertex_count('1);
        issue_request(REQ_READ_VAL, SLOT_W'(MAX_EDGES - 1), 32'd0);
    endtask

    task automatic test_random_graphs();
        int unsigned phase_end;
        phase_end = requests_sent;
        for (int mode = 0; mode < 3; mode++)
        begin
            idle_pct   = (mode == 0) ? 28 : ((mode == 1) ? 71 : 0);
            phase_end += RANDOM_REQUESTS / 3;
            write_vertex_count((mode == 0) ? VC_W'(1) :
                               ((mode == 1) ? VC_W'(MAX_VERTICES) : random_vertex_count()));
            while (requests_sent < phase_end)
            begin
                case ($urandom_range(0, 19))
                    0:       write_vertex_count(random_vertex_count());
                    1:       wait_for_results();
                    2, 3, 4: send_stray_requests();
                    default: build_and_average_window();
                endcase
            end
        end
    endtask

    // Check each result word against the oldest prediction
    initial
    begin
        level_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: value %h status %0d", value, status);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (value !== want.value)
                    begin
                        $error("value mismatch: expected %h, got %h", want.value, value);
                        mismatch_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d", want.status, status);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_loads_and_bounds();
        test_compute_cases();
        test_vertex_count_limits();
        test_random_graphs();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
